// ===== sv/mtg_pkg.sv =====
// Package for the mesh tangent generator: sizes, action codes and fixed-point helpers.
package mtg_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int TAN_W        = 18;
  localparam int ACC_W        = 40;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TRI   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // Q16.16 one, minus one, used to bias negative products before the shift.
  localparam logic signed [65:0] Q_BIAS = 66'sd65535;

  // Difference of two Q16.16 values, saturated to 32 bits.
  function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sat_sub32 = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sub32 = d[31:0];
    end
  endfunction

  // Full product divided by 65536, truncated toward zero.
  function automatic logic signed [63:0] qscale(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p + (p[65] ? Q_BIAS : 66'sd0);
    qscale = {{14{t[65]}}, t[65:16]};
  endfunction

  // Sum that has grown by one bit, saturated back to the accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_acc = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_acc = s[ACC_W-1:0];
    end
  endfunction

  // Signed 64-bit value saturated to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Magnitude of a signed value, kept to 50 bits.
  function automatic logic [49:0] mag50(input logic signed [63:0] v);
    logic signed [63:0] a;
    a = v[63] ? -v : v;
    mag50 = a[49:0];
  endfunction

endpackage

// ===== sv/mesh_tangent_generator_core.sv =====
// Mesh tangent generator: vertex stores, triangle tangent accumulation and tangent readout.
// Triangle and readout time is set by the one shared multiplier, the bit-pair square root
// (32 steps) and the restoring divider (17 steps per component). A clear writes one
// accumulator row per cycle; the same clearing pass runs after reset, during which no
// beat is accepted. The result register frees the input side early.
module mesh_tangent_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       action,
  input  logic signed [31:0]               pos_x,
  input  logic signed [31:0]               pos_y,
  input  logic signed [31:0]               pos_z,
  input  logic signed [31:0]               norm_x,
  input  logic signed [31:0]               norm_y,
  input  logic signed [31:0]               norm_z,
  input  logic signed [31:0]               tex_u,
  input  logic signed [31:0]               tex_v,
  input  logic [mtg_pkg::IDX_W-1:0]        idx_a,
  input  logic [mtg_pkg::IDX_W-1:0]        idx_b,
  input  logic [mtg_pkg::IDX_W-1:0]        idx_c,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mtg_pkg::IDX_W-1:0]        vertex_index,
  output logic signed [mtg_pkg::TAN_W-1:0] tan_x,
  output logic signed [mtg_pkg::TAN_W-1:0] tan_y,
  output logic signed [mtg_pkg::TAN_W-1:0] tan_z,
  output logic                             degenerate
);
  import mtg_pkg::*;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_TRI_RD   = 4'd2;
  localparam logic [3:0] ST_RO_CAP   = 4'd3;
  localparam logic [3:0] ST_MUL      = 4'd4;
  localparam logic [3:0] ST_ACC      = 4'd5;
  localparam logic [3:0] ST_SCALE    = 4'd6;
  localparam logic [3:0] ST_SQRT     = 4'd7;
  localparam logic [3:0] ST_DIV_INIT = 4'd8;
  localparam logic [3:0] ST_DIV      = 4'd9;
  localparam logic [3:0] ST_ACC_RD   = 4'd10;
  localparam logic [3:0] ST_ACC_WR   = 4'd11;
  localparam logic [3:0] ST_OUT      = 4'd12;

  localparam logic [4:0] U_DET0 = 5'd0;
  localparam logic [4:0] U_DET1 = 5'd1;
  localparam logic [4:0] U_T0A  = 5'd2;
  localparam logic [4:0] U_T0B  = 5'd3;
  localparam logic [4:0] U_T1A  = 5'd4;
  localparam logic [4:0] U_T1B  = 5'd5;
  localparam logic [4:0] U_T2A  = 5'd6;
  localparam logic [4:0] U_T2B  = 5'd7;
  localparam logic [4:0] U_DOT0 = 5'd8;
  localparam logic [4:0] U_DOT1 = 5'd9;
  localparam logic [4:0] U_DOT2 = 5'd10;
  localparam logic [4:0] U_R0   = 5'd11;
  localparam logic [4:0] U_R1   = 5'd12;
  localparam logic [4:0] U_R2   = 5'd13;
  localparam logic [4:0] U_SQ0  = 5'd14;
  localparam logic [4:0] U_SQ1  = 5'd15;
  localparam logic [4:0] U_SQ2  = 5'd16;

  localparam logic [1:0] PH_TRI    = 2'd0;
  localparam logic [1:0] PH_RO_ACC = 2'd1;
  localparam logic [1:0] PH_RO_R   = 2'd2;

  localparam logic [49:0] SCALE_HI = 50'd1 << 30;
  localparam logic [49:0] SCALE_LO = 50'd1 << 29;

  logic [3:0]  state;
  logic [4:0]  uop;
  logic [1:0]  phase;
  logic [1:0]  cnt;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] ca, cb, cc;

  // Vertex and accumulator stores, one row per vertex.
  logic [95:0]  pos_mem  [MAX_VERTICES];
  logic [95:0]  norm_mem [MAX_VERTICES];
  logic [63:0]  uv_mem   [MAX_VERTICES];
  logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];
  logic [95:0]  pos_rd, norm_rd;
  logic [63:0]  uv_rd;
  logic [3*ACC_W-1:0] acc_rd;
  logic [IDX_W-1:0] rd_addr;
  logic         acc_we;
  logic [IDX_W-1:0] acc_wa;
  logic [3*ACC_W-1:0] acc_wd;

  // Triangle operands.
  logic signed [31:0] pa [3];
  logic signed [31:0] ua [2];
  logic signed [31:0] e1 [3];
  logic signed [31:0] e2 [3];
  logic signed [31:0] du1, dv1, du2, dv2;
  logic               det_neg;

  // Readout operands.
  logic signed [31:0] nr [3];
  logic signed [31:0] dotr;
  logic [IDX_W-1:0]   vidx;

  // Shared vector under normalization.
  logic [49:0] mag [3];
  logic        sgn [3];
  logic [49:0] mx;

  // Shared multiplier and accumulator.
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic signed [63:0] accr, term, acc_new, acc_base, stv;
  logic               op_sub;
  logic [1:0]         op_i;
  logic signed [32:0] a_op [3];

  // Square root and divider.
  logic [63:0] sq_x, sq_r, sq_b, sq_rb, sq_x_next, sq_r_next;
  logic [31:0] len;
  logic [31:0] rem;
  logic [16:0] dsr, quo;
  logic [4:0]  div_cnt;
  logic [1:0]  div_i;
  logic [32:0] div_t;
  logic        div_ge;
  logic [16:0] quo_next;
  logic [TAN_W-1:0] res_val;
  logic signed [TAN_W-1:0] res [3];
  logic        res_deg;

  logic        in_acc;
  logic signed [ACC_W-1:0] acc_old [3];
  logic signed [ACC_W-1:0] acc_sum [3];

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Read address follows the sequencer.
  always_comb begin
    case (state)
      ST_IDLE:   rd_addr = idx_a;
      ST_TRI_RD: rd_addr = (cnt == 2'd0) ? cb : cc;
      ST_ACC_RD, ST_ACC_WR: begin
        case (cnt)
          2'd0:    rd_addr = ca;
          2'd1:    rd_addr = cb;
          default: rd_addr = cc;
        endcase
      end
      default:   rd_addr = ca;
    endcase
  end

  // Accumulator store write port: clearing pass or read-modify-write.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_old[i] = acc_rd[i*ACC_W +: ACC_W];
      acc_sum[i] = sat_acc({acc_old[i][ACC_W-1], acc_old[i]} +
                           {{(ACC_W+1-TAN_W){res[i][TAN_W-1]}}, res[i]});
    end
    acc_we = (state == ST_CLEAR) || (state == ST_ACC_WR);
    acc_wa = (state == ST_CLEAR) ? clr_addr : rd_addr;
    acc_wd = (state == ST_CLEAR) ? '0 : {acc_sum[2], acc_sum[1], acc_sum[0]};
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (in_acc && action == ACT_LOAD) begin
      pos_mem[idx_a]  <= {pos_z, pos_y, pos_x};
      norm_mem[idx_a] <= {norm_z, norm_y, norm_x};
      uv_mem[idx_a]   <= {tex_v, tex_u};
    end
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    pos_rd  <= pos_mem[rd_addr];
    norm_rd <= norm_mem[rd_addr];
    uv_rd   <= uv_mem[rd_addr];
    acc_rd  <= acc_mem[rd_addr];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_op[i] = sgn[i] ? -$signed({1'b0, mag[i][31:0]}) : $signed({1'b0, mag[i][31:0]});
    end
    op_i   = 2'd0;
    op_sub = 1'b0;
    opa    = '0;
    opb    = '0;
    case (uop)
      U_DET0: begin opa = {du1[31], du1}; opb = {dv2[31], dv2}; end
      U_DET1: begin opa = {du2[31], du2}; opb = {dv1[31], dv1}; op_sub = 1'b1; end
      U_T0A, U_T1A, U_T2A: begin
        op_i = (uop == U_T0A) ? 2'd0 : ((uop == U_T1A) ? 2'd1 : 2'd2);
        opa  = {dv2[31], dv2};
        opb  = {e1[op_i][31], e1[op_i]};
      end
      U_T0B, U_T1B, U_T2B: begin
        op_i   = (uop == U_T0B) ? 2'd0 : ((uop == U_T1B) ? 2'd1 : 2'd2);
        opa    = {dv1[31], dv1};
        opb    = {e2[op_i][31], e2[op_i]};
        op_sub = 1'b1;
      end
      U_DOT0, U_DOT1, U_DOT2: begin
        op_i = (uop == U_DOT0) ? 2'd0 : ((uop == U_DOT1) ? 2'd1 : 2'd2);
        opa  = a_op[op_i];
        opb  = {nr[op_i][31], nr[op_i]};
      end
      U_R0, U_R1, U_R2: begin
        op_i   = (uop == U_R0) ? 2'd0 : ((uop == U_R1) ? 2'd1 : 2'd2);
        opa    = {dotr[31], dotr};
        opb    = {nr[op_i][31], nr[op_i]};
        op_sub = 1'b1;
      end
      U_SQ0, U_SQ1, U_SQ2: begin
        op_i = (uop == U_SQ0) ? 2'd0 : ((uop == U_SQ1) ? 2'd1 : 2'd2);
        opa  = $signed({1'b0, mag[op_i][31:0]});
        opb  = $signed({1'b0, mag[op_i][31:0]});
      end
      default: begin end
    endcase
    acc_base = (uop == U_R0 || uop == U_R1 || uop == U_R2) ?
               {{31{a_op[op_i][32]}}, a_op[op_i]} : 64'sd0;
    term     = (uop == U_SQ0 || uop == U_SQ1 || uop == U_SQ2) ? prod[63:0] : qscale(prod);
    acc_new  = op_sub ? (accr - term) : (accr + term);
    stv      = det_neg ? -acc_new : acc_new;
  end

  // Largest magnitude of the vector under normalization.
  always_comb begin
    mx = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mx) begin
      mx = mag[2];
    end
  end

  // One square root step and one divider step.
  always_comb begin
    sq_rb = sq_r + sq_b;
    if (sq_x >= sq_rb) begin
      sq_x_next = sq_x - sq_rb;
      sq_r_next = (sq_r >> 1) + sq_b;
    end else begin
      sq_x_next = sq_x;
      sq_r_next = sq_r >> 1;
    end
    div_t    = {rem, dsr[16]};
    div_ge   = div_t >= {1'b0, len};
    quo_next = {quo[15:0], div_ge};
    res_val  = sgn[div_i] ? -{1'b0, quo_next} : {1'b0, quo_next};
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one is loaded below.
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(MAX_VERTICES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            ca   <= idx_a;
            cb   <= idx_b;
            cc   <= idx_c;
            vidx <= idx_a;
            cnt  <= 2'd0;
            case (action)
              ACT_TRI:   state <= ST_TRI_RD;
              ACT_READ:  state <= ST_RO_CAP;
              ACT_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_TRI_RD: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd0) begin
            pa[0] <= pos_rd[31:0];
            pa[1] <= pos_rd[63:32];
            pa[2] <= pos_rd[95:64];
            ua[0] <= uv_rd[31:0];
            ua[1] <= uv_rd[63:32];
          end else if (cnt == 2'd1) begin
            e1[0] <= sat_sub32(pos_rd[31:0], pa[0]);
            e1[1] <= sat_sub32(pos_rd[63:32], pa[1]);
            e1[2] <= sat_sub32(pos_rd[95:64], pa[2]);
            du1   <= sat_sub32(uv_rd[31:0], ua[0]);
            dv1   <= sat_sub32(uv_rd[63:32], ua[1]);
          end else begin
            e2[0] <= sat_sub32(pos_rd[31:0], pa[0]);
            e2[1] <= sat_sub32(pos_rd[63:32], pa[1]);
            e2[2] <= sat_sub32(pos_rd[95:64], pa[2]);
            du2   <= sat_sub32(uv_rd[31:0], ua[0]);
            dv2   <= sat_sub32(uv_rd[63:32], ua[1]);
            phase <= PH_TRI;
            uop   <= U_DET0;
            state <= ST_MUL;
          end
        end
        ST_RO_CAP: begin
          for (int i = 0; i < 3; i++) begin
            sgn[i] <= acc_rd[i*ACC_W + ACC_W - 1];
            mag[i] <= mag50({{(64-ACC_W){acc_rd[i*ACC_W + ACC_W - 1]}},
                             acc_rd[i*ACC_W +: ACC_W]});
            nr[i]  <= norm_rd[i*32 +: 32];
          end
          phase <= PH_RO_ACC;
          state <= ST_SCALE;
        end
        ST_MUL: begin
          prod <= opa * opb;
          if (uop == U_DET0 || uop == U_T0A || uop == U_T1A || uop == U_T2A ||
              uop == U_DOT0 || uop == U_SQ0 || uop == U_R0 || uop == U_R1 ||
              uop == U_R2) begin
            accr <= acc_base;
          end
          state <= ST_ACC;
        end
        ST_ACC: begin
          accr  <= acc_new;
          state <= ST_MUL;
          case (uop)
            U_DET1: begin
              if (acc_new == 64'sd0) begin
                state <= ST_IDLE;
              end
              det_neg <= acc_new[63];
              uop     <= U_T0A;
            end
            U_T0B, U_T1B, U_T2B: begin
              sgn[op_i] <= stv[63];
              mag[op_i] <= mag50(stv);
              if (uop == U_T2B) begin
                state <= ST_SCALE;
              end else begin
                uop <= uop + 5'd1;
              end
            end
            U_DOT2: begin
              dotr <= sat32(acc_new);
              uop  <= U_R0;
            end
            U_R0, U_R1, U_R2: begin
              sgn[op_i] <= acc_new[63];
              mag[op_i] <= mag50(acc_new);
              if (uop == U_R2) begin
                phase <= PH_RO_R;
                state <= ST_SCALE;
              end else begin
                uop <= uop + 5'd1;
              end
            end
            U_SQ2: begin
              sq_x  <= acc_new;
              sq_r  <= '0;
              sq_b  <= 64'd1 << 62;
              state <= ST_SQRT;
            end
            default: uop <= uop + 5'd1;
          endcase
        end
        ST_SCALE: begin
          // Shift the vector a bit a cycle until the largest magnitude is in range.
          if (mx == '0) begin
            res[0]  <= '0;
            res[1]  <= '0;
            res[2]  <= '0;
            res_deg <= 1'b1;
            state   <= (phase == PH_TRI) ? ST_IDLE : ST_OUT;
          end else if (mx >= SCALE_HI) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (mx < SCALE_LO) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            uop   <= (phase == PH_RO_ACC) ? U_DOT0 : U_SQ0;
            state <= ST_MUL;
          end
        end
        ST_SQRT: begin
          sq_x <= sq_x_next;
          sq_r <= sq_r_next;
          sq_b <= sq_b >> 2;
          if (sq_b[0]) begin
            len   <= sq_r_next[31:0];
            div_i <= 2'd0;
            state <= ST_DIV_INIT;
          end
        end
        ST_DIV_INIT: begin
          // Dividend is the magnitude times 65536; the top part is already below len.
          rem     <= {2'b00, mag[div_i][30:1]};
          dsr     <= {mag[div_i][0], 16'd0};
          quo     <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem     <= div_ge ? 32'(div_t - {1'b0, len}) : div_t[31:0];
          dsr     <= {dsr[15:0], 1'b0};
          quo     <= quo_next;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd16) begin
            res[div_i] <= res_val;
            if (div_i == 2'd2) begin
              res_deg <= 1'b0;
              cnt     <= 2'd0;
              state   <= (phase == PH_TRI) ? ST_ACC_RD : ST_OUT;
            end else begin
              div_i <= div_i + 2'd1;
              state <= ST_DIV_INIT;
            end
          end
        end
        ST_ACC_RD: begin
          state <= ST_ACC_WR;
        end
        ST_ACC_WR: begin
          cnt <= cnt + 2'd1;
          state <= (cnt == 2'd2) ? ST_IDLE : ST_ACC_RD;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            vertex_index <= vidx;
            tan_x        <= res[0];
            tan_y        <= res[1];
            tan_z        <= res[2];
            degenerate   <= res_deg;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/mesh_tangent_generator_core_tb.sv =====
// Self-checking testbench for the mesh tangent generator: directed table, then random mesh traffic.
module mesh_tangent_generator_core_tb;
  import mtg_pkg::*;

  localparam int NV = MAX_VERTICES;
  localparam longint ACC_MAX = 64'sd549755813887;
  localparam longint ACC_MIN = -64'sd549755813888;
  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_BEATS = 1430;

  typedef struct {
    logic [1:0] act;
    logic signed [31:0] px, py, pz, nx, ny, nz, tu, tv;
    logic [9:0] ia, ib, ic;
  } beat_t;

  typedef struct {
    logic [9:0] vidx;
    logic signed [17:0] tx, ty, tz;
    logic degen;
  } tangent_t;

  // Directed row: a beat plus an optional typed-in expectation.
  typedef struct {
    beat_t b;
    bit fixed;
    tangent_t want;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] action;
  logic signed [31:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v;
  logic [9:0] idx_a, idx_b, idx_c;
  logic [9:0] vertex_index;
  logic signed [17:0] tan_x, tan_y, tan_z;
  logic degenerate;

  mesh_tangent_generator_core dut (.*);

  // Predictor state.
  longint pos_mem[NV][3];
  longint nrm_mem[NV][3];
  longint uv_mem[NV][2];
  longint tan_acc[NV][3];
  bit written[NV];

  tangent_t pending_q[$];
  beat_t send_q[$];
  row_t rows[$];
  int errors = 0;
  int beats_in = 0, beats_out = 0, degen_seen = 0;
  int idle_cycles = 0;
  bit quiet_phase = 0;
  bit hold_off = 0;
  bit all_sent = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Q16.16 product, truncated toward zero.
  function automatic longint qmul(longint a, longint b);
    return (a * b) / 65536;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // Shift so the largest magnitude lands in [2^29, 2^30).
  function automatic bit rescale(input longint v[3], output longint o[3]);
    longint unsigned m[3], mx;
    int up, down;
    mx = 0;
    up = 0;
    down = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while ((mx >> down) >= (64'd1 << 30)) down++;
    while ((mx << up) < (64'd1 << 29)) up++;
    for (int i = 0; i < 3; i++) o[i] = v[i] < 0 ? -longint'((m[i] >> down) << up)
                                                 : longint'((m[i] >> down) << up);
    return 1;
  endfunction

  function automatic bit unit_vec(input longint v[3], output longint o[3]);
    longint s[3];
    longint unsigned sum, len, m;
    if (!rescale(v, s)) return 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = s[i] < 0 ? -s[i] : s[i];
      sum += m * m;
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      m = s[i] < 0 ? -s[i] : s[i];
      m = (m * 65536) / len;
      o[i] = s[i] < 0 ? -longint'(m) : longint'(m);
    end
    return 1;
  endfunction

  // Apply one accepted beat to the predictor; push a tangent if one is due.
  task automatic predict_beat(input beat_t b, input bit fixed, input tangent_t want);
    longint e1[3], e2[3], t[3], u[3], a[3], r[3], res[3];
    longint du1, dv1, du2, dv2, det, dot;
    tangent_t exp_t;
    bit ok;
    case (b.act)
      ACT_LOAD: begin
        pos_mem[b.ia] = '{b.px, b.py, b.pz};
        nrm_mem[b.ia] = '{b.nx, b.ny, b.nz};
        uv_mem[b.ia] = '{b.tu, b.tv};
        written[b.ia] = 1;
      end
      ACT_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = clip(pos_mem[b.ib][i] - pos_mem[b.ia][i], W_MIN, W_MAX);
          e2[i] = clip(pos_mem[b.ic][i] - pos_mem[b.ia][i], W_MIN, W_MAX);
        end
        du1 = clip(uv_mem[b.ib][0] - uv_mem[b.ia][0], W_MIN, W_MAX);
        dv1 = clip(uv_mem[b.ib][1] - uv_mem[b.ia][1], W_MIN, W_MAX);
        du2 = clip(uv_mem[b.ic][0] - uv_mem[b.ia][0], W_MIN, W_MAX);
        dv2 = clip(uv_mem[b.ic][1] - uv_mem[b.ia][1], W_MIN, W_MAX);
        det = qmul(du1, dv2) - qmul(du2, dv1);
        if (det != 0) begin
          for (int i = 0; i < 3; i++) begin
            t[i] = qmul(dv2, e1[i]) - qmul(dv1, e2[i]);
            if (det < 0) t[i] = -t[i];
          end
          if (unit_vec(t, u)) begin
            for (int i = 0; i < 3; i++) begin
              tan_acc[b.ia][i] = clip(tan_acc[b.ia][i] + u[i], ACC_MIN, ACC_MAX);
              tan_acc[b.ib][i] = clip(tan_acc[b.ib][i] + u[i], ACC_MIN, ACC_MAX);
              tan_acc[b.ic][i] = clip(tan_acc[b.ic][i] + u[i], ACC_MIN, ACC_MAX);
            end
          end
        end
      end
      ACT_CLEAR: begin
        foreach (tan_acc[v, i]) tan_acc[v][i] = 0;
      end
      default: begin
        ok = rescale(tan_acc[b.ia], a);
        if (ok) begin
          dot = 0;
          for (int i = 0; i < 3; i++) dot += qmul(a[i], nrm_mem[b.ia][i]);
          dot = clip(dot, W_MIN, W_MAX);
          for (int i = 0; i < 3; i++) r[i] = a[i] - qmul(dot, nrm_mem[b.ia][i]);
          ok = unit_vec(r, res);
        end
        exp_t.vidx = b.ia;
        exp_t.tx = ok ? res[0][17:0] : '0;
        exp_t.ty = ok ? res[1][17:0] : '0;
        exp_t.tz = ok ? res[2][17:0] : '0;
        exp_t.degen = !ok;
        if (fixed && exp_t != want) begin
          $display("%0t: table expectation disagrees with predictor for vertex %0d", $time,
                   b.ia);
          errors++;
        end
        pending_q.push_back(fixed ? want : exp_t);
      end
    endcase
  endtask

  function automatic beat_t mk(logic [1:0] act, logic [9:0] ia, logic [9:0] ib,
                               logic [9:0] ic);
    beat_t b;
    b.act = act;
    b.ia = ia;
    b.ib = ib;
    b.ic = ic;
    b.px = $urandom; b.py = $urandom; b.pz = $urandom;
    b.nx = $urandom; b.ny = $urandom; b.nz = $urandom;
    b.tu = $urandom; b.tv = $urandom;
    return b;
  endfunction

  function automatic beat_t mk_vertex(logic [9:0] ia, longint x, longint y, longint z,
                                      longint nz, longint u, longint v);
    beat_t b;
    b = mk(ACT_LOAD, ia, 0, 0);
    b.px = x; b.py = y; b.pz = z;
    b.nx = 0; b.ny = 0; b.nz = nz;
    b.tu = u; b.tv = v;
    return b;
  endfunction

  task automatic add_row(beat_t b, bit fixed = 0, tangent_t want = '{0, 0, 0, 0, 0});
    row_t r;
    r.b = b;
    r.fixed = fixed;
    r.want = want;
    rows.push_back(r);
  endtask

  // Directed table: extremes, every action and the skip and degenerate cases.
  task automatic build_table();
    beat_t b;
    add_row(mk(ACT_READ, 10'd0, 0, 0), 1, '{10'd0, 0, 0, 0, 1'b1});
    // A unit right triangle in the z=0 plane with u along x.
    add_row(mk_vertex(10'd0, 0, 0, 0, 65536, 0, 0));
    add_row(mk_vertex(10'd1, 65536, 0, 0, 65536, 65536, 0));
    add_row(mk_vertex(10'd2, 0, 65536, 0, 65536, 0, 65536));
    add_row(mk(ACT_TRI, 10'd0, 10'd1, 10'd2));
    add_row(mk(ACT_READ, 10'd0, 0, 0), 1, '{10'd0, 18'sd65536, 0, 0, 1'b0});
    add_row(mk(ACT_READ, 10'd2, 0, 0));
    // Mirrored UV gives a negative determinant.
    add_row(mk_vertex(10'd3, 0, 0, 0, 65536, 0, 0));
    add_row(mk_vertex(10'd4, 65536, 0, 0, 65536, -65536, 0));
    add_row(mk_vertex(10'd5, 0, 65536, 0, 65536, 0, 65536));
    add_row(mk(ACT_TRI, 10'd3, 10'd4, 10'd5));
    add_row(mk(ACT_READ, 10'd4, 0, 0));
    // Zero determinant: all UVs equal, triangle is skipped.
    add_row(mk_vertex(10'd6, 0, 0, 0, 65536, 7, 7));
    add_row(mk_vertex(10'd7, 3, 9, 1, 65536, 7, 7));
    add_row(mk(ACT_TRI, 10'd6, 10'd7, 10'd7));
    add_row(mk(ACT_READ, 10'd6, 0, 0), 1, '{10'd6, 0, 0, 0, 1'b1});
    // Extreme positions and UVs saturate the edge differences.
    b = mk(ACT_LOAD, 10'd1023, 0, 0);
    b.px = 32'sh7fffffff; b.py = 32'sh80000000; b.pz = 32'sh7fffffff;
    b.tu = 32'sh7fffffff; b.tv = 32'sh80000000;
    b.nx = 32'sh80000000; b.ny = 32'sh7fffffff; b.nz = 32'sh0;
    add_row(b);
    b = mk(ACT_LOAD, 10'd1022, 0, 0);
    b.px = 32'sh80000000; b.py = 32'sh7fffffff; b.pz = 32'sh0;
    b.tu = 32'sh80000000; b.tv = 32'sh7fffffff;
    add_row(b);
    add_row(mk(ACT_TRI, 10'd1023, 10'd1022, 10'd0));
    add_row(mk(ACT_READ, 10'd1023, 0, 0));
    add_row(mk(ACT_READ, 10'd1022, 0, 0));
    // Vertex 8 is loaded with a zero normal.
    add_row(mk_vertex(10'd8, 0, 0, 0, 0, 0, 0));
    add_row(mk(ACT_CLEAR, 0, 0, 0));
    add_row(mk(ACT_READ, 10'd0, 0, 0), 1, '{10'd0, 0, 0, 0, 1'b1});
  endtask

  // Random traffic: loads, triangles over loaded slots, readouts and rare clears.
  task automatic build_random();
    beat_t b;
    int loaded[$];
    int pick, s;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      pick = $urandom_range(0, 99);
      if (loaded.size() < 3 || pick < 25) begin
        s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
        b = mk(ACT_LOAD, s, $urandom, $urandom);
        if ($urandom_range(0, 2) != 0) begin
          // Moderate magnitudes keep most triangles non-degenerate.
          b.px = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          b.py = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          b.pz = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          b.tu = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
          b.tv = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
          b.nx = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
          b.ny = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
          b.nz = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        end
        if (!written[s]) loaded.push_back(s);
        written[s] = 1;
      end else if (pick < 65) begin
        b = mk(ACT_TRI, loaded[$urandom_range(0, loaded.size() - 1)],
               loaded[$urandom_range(0, loaded.size() - 1)],
               loaded[$urandom_range(0, loaded.size() - 1)]);
      end else if (pick < 98) begin
        b = mk(ACT_READ, loaded[$urandom_range(0, loaded.size() - 1)], $urandom, $urandom);
      end else begin
        b = mk(ACT_CLEAR, $urandom, $urandom, $urandom);
      end
      send_q.push_back(b);
    end
  endtask

  task automatic drive(beat_t b);
    action <= b.act;
    pos_x <= b.px; pos_y <= b.py; pos_z <= b.pz;
    norm_x <= b.nx; norm_y <= b.ny; norm_z <= b.nz;
    tex_u <= b.tu; tex_v <= b.tv;
    idx_a <= b.ia; idx_b <= b.ib; idx_c <= b.ic;
  endtask

  function automatic bit gap_now();
    return !quiet_phase && $urandom_range(0, 99) < 18;
  endfunction

  // Sender: directed rows, then random beats; valid holds until accepted.
  initial begin
    beat_t b;
    row_t r;
    bit fixed;
    tangent_t want;
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    drive(mk(ACT_LOAD, 0, 0, 0));
    foreach (written[i]) written[i] = 0;
    build_table();
    foreach (pos_mem[v, i]) begin
      pos_mem[v][i] = 0; nrm_mem[v][i] = 0; tan_acc[v][i] = 0;
    end
    foreach (uv_mem[v, i]) uv_mem[v][i] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    // The random builder tracks loaded slots in the same flags, seeded from the table's loads.
    foreach (rows[k]) if (rows[k].b.act == ACT_LOAD) written[rows[k].b.ia] = 1;
    build_random();
    for (int k = 0; k < rows.size() + send_q.size(); k++) begin
      if (k < rows.size()) begin
        r = rows[k];
      end else begin
        r.b = send_q[k - rows.size()];
        r.fixed = 0;
      end
      while (gap_now()) begin
        in_valid <= 0;
        @(posedge clk);
      end
      drive(r.b);
      in_valid <= 1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      predict_beat(r.b, r.fixed, r.want);
      beats_in++;
      // Quiet stretch and receiver hold-off in the random part.
      if (k == rows.size() + 300) quiet_phase = 1;
      if (k == rows.size() + 500) quiet_phase = 0;
      if (k == rows.size() + 700) hold_off = 1;
    end
    in_valid <= 0;
    all_sent = 1;
  end

  // Long receiver hold-off, counted here.
  initial begin
    wait (hold_off);
    repeat (3000) @(posedge clk);
    hold_off = 0;
  end

  // Receiver: random ready, compare each beat to the oldest expectation.
  always @(posedge clk) begin
    tangent_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected tangent for vertex %0d", $time, vertex_index);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (degenerate) degen_seen++;
          if ({vertex_index, tan_x, tan_y, tan_z, degenerate} !=
              {e.vidx, e.tx, e.ty, e.tz, e.degen}) begin
            $display("%0t: mismatch expected idx=%0d t=(%0d,%0d,%0d) deg=%0d", $time,
                     e.vidx, e.tx, e.ty, e.tz, e.degen);
            $display("%0t:          actual   idx=%0d t=(%0d,%0d,%0d) deg=%0d", $time,
                     vertex_index, tan_x, tan_y, tan_z, degenerate);
            errors++;
          end
        end
      end
      out_ready <= !hold_off && (quiet_phase || $urandom_range(0, 99) >= 18);
    end
  end

  // Watchdog and end of run.
  initial begin
    int drain;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
      if (all_sent && pending_q.size() == 0) break;
    end
    drain = 0;
    while (drain < 400) begin
      @(posedge clk);
      drain++;
    end
    if (pending_q.size() != 0 || out_valid) begin
      if (out_valid) $display("%0t: tangent output after all expectations met", $time);
      errors++;
    end
    $display("Sent %0d beats, checked %0d tangents (%0d degenerate), with stalls",
             beats_in, beats_out, degen_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
